// File: sv/ilcdw_pkg.sv
// Package for the LCD port-expander writer: beat types, register indexes,
// sequencer phases and the expander bit layout. Depends on nothing.
package ilcdw_pkg;

  // Command kinds carried in the kind field of an input beat
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_NIBBLE = 2'd2,
    KIND_LIGHT  = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_SLAVE_ADDRESS     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_STROBE_GAP_TICKS  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE_HOLD_TICKS = 8'd2;

  // Register reset values
  localparam logic [6:0] SLAVE_ADDRESS_RST     = 7'd39;
  localparam logic [7:0] STROBE_GAP_TICKS_RST  = 8'd1;
  localparam logic [7:0] ENABLE_HOLD_TICKS_RST = 8'd10;

  // Expander bit layout: D7..D4, BL, EN, RW, RS
  localparam logic [7:0] NIB_HIGH_MASK = 8'hF0;
  localparam logic [7:0] NIB_LOW_MASK  = 8'h0F;
  localparam logic [7:0] BIT_RS        = 8'h01;
  localparam logic [7:0] BIT_EN        = 8'h04;
  localparam logic [7:0] BIT_BL        = 8'h08;
  localparam logic [2:0] TOP_BIT       = 3'd7;

  // Line sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST0  = 4'd1,
    PH_ST1  = 4'd2,
    PH_ST2  = 4'd3,
    PH_ST3  = 4'd4,
    PH_B0   = 4'd5,
    PH_B1   = 4'd6,
    PH_B2   = 4'd7,
    PH_A0   = 4'd8,
    PH_A1   = 4'd9,
    PH_A2   = 4'd10,
    PH_P0   = 4'd11,
    PH_P1   = 4'd12,
    PH_P2   = 4'd13,
    PH_WAIT = 4'd14
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       reg_select;
    logic       light_on;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_release;
    logic sda_release;
    logic busy_res;
    logic accepted;
    logic nack_seen;
    logic done_res;
  } out_item_t;

  // Register values seen by the sequencer
  typedef struct packed {
    logic [6:0] slave_address;
    logic [7:0] strobe_gap_ticks;
    logic [7:0] enable_hold_ticks;
  } cfg_t;

endpackage

// File: sv/i2c_lcd_expander_writer.sv
// Top level of the LCD port-expander writer: input and result registers
// around the line sequencer. Depends on ilcdw_pkg, ilcdw_cfg_regs, ilcdw_seq.
//
//   channel   handshake                 payload
//   in        in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out       out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per clock unless the result register stalls; a beat's result is
// offered on out_item_o after the input register and then the result
// register. Each tick beat steps a busy sequencer. Reset puts both lines
// released, sequencer idle and the registers at their defaults. A stalled
// result register holds the input register, which then stalls the input side.
module i2c_lcd_expander_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ilcdw_pkg::in_item_t           in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ilcdw_pkg::out_item_t          out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ilcdw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import ilcdw_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t res;
  cfg_t      cfg;
  logic      advance, step;

  ilcdw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance when the result register is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  ilcdw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: sv/ilcdw_cfg_regs.sv
// Configuration register file of the LCD port-expander writer.
// Depends on ilcdw_pkg for register indexes, reset values and cfg_t.
module ilcdw_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ilcdw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  output ilcdw_pkg::cfg_t               cfg_o
);
  import ilcdw_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Decode the index; drop writes beyond the register list
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SLAVE_ADDRESS:     cfg_d.slave_address     = cfg_data_i[6:0];
        CFG_STROBE_GAP_TICKS:  cfg_d.strobe_gap_ticks  = cfg_data_i;
        CFG_ENABLE_HOLD_TICKS: cfg_d.enable_hold_ticks = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address     <= SLAVE_ADDRESS_RST;
      cfg_q.strobe_gap_ticks  <= STROBE_GAP_TICKS_RST;
      cfg_q.enable_hold_ticks <= ENABLE_HOLD_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/ilcdw_seq.sv
// Line sequencer: holds the I2C bit-bang state and works out one step per
// beat, giving the result beat. Depends on ilcdw_pkg.
module ilcdw_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ilcdw_pkg::in_item_t  item_i,
  input  ilcdw_pkg::cfg_t      cfg_i,
  output ilcdw_pkg::out_item_t res_o
);
  import ilcdw_pkg::*;

  phase_e     phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] left_q, left_d;
  logic       addr_q, addr_d;
  logic [7:0] wait_q, wait_d;
  logic       bl_q, bl_d;
  logic [7:0] pend_q, pend_d;
  logic       rs_q, rs_d;
  logic       nack_q, nack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       light_q, light_d;

  logic       is_tick, idle, take, adv;
  logic [7:0] wait_sel, wait_dec;
  logic [2:0] left_dec;
  logic       last_frame, done;

  // Data byte of the current expander write
  function automatic logic [7:0] frame_data(input logic       light,
                                            input logic [7:0] pend,
                                            input logic [2:0] left,
                                            input logic       rs,
                                            input logic       bl);
    logic [3:0] nib;
    logic [7:0] d;
    nib = (left >= 3'd3) ? pend[7:4] : pend[3:0];
    d   = {nib, 4'b0000} & NIB_HIGH_MASK;
    if (rs)       d = d | BIT_RS;
    if (bl)       d = d | BIT_BL;
    if (!left[0]) d = d | BIT_EN;
    return light ? pend : d;
  endfunction

  assign is_tick    = (item_i.kind == KIND_TICK);
  assign idle       = (phase_q == PH_IDLE);
  assign take       = step_i && !is_tick && idle;
  assign adv        = step_i && is_tick && !idle;
  assign wait_sel   = left_q[0] ? cfg_i.enable_hold_ticks : cfg_i.strobe_gap_ticks;
  assign wait_dec   = (wait_q != 8'd0) ? wait_q - 8'd1 : wait_q;
  assign left_dec   = left_q - 3'd1;
  assign last_frame = light_q || (left_q == 3'd0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      phase_d = PH_ST0;
    end else if (adv) begin
      unique case (phase_q)
        PH_ST0:  phase_d = PH_ST1;
        PH_ST1:  phase_d = PH_ST2;
        PH_ST2:  phase_d = PH_ST3;
        PH_ST3:  phase_d = PH_B0;
        PH_B0:   phase_d = PH_B1;
        PH_B1:   phase_d = PH_B2;
        PH_B2:   phase_d = (bit_q == 3'd0) ? PH_A0 : PH_B0;
        PH_A0:   phase_d = PH_A1;
        PH_A1:   phase_d = PH_A2;
        PH_A2:   phase_d = addr_q ? PH_B0 : PH_P0;
        PH_P0:   phase_d = PH_P1;
        PH_P1:   phase_d = PH_P2;
        PH_P2: begin
          if (last_frame)                phase_d = PH_IDLE;
          else if (wait_sel != 8'd0)     phase_d = PH_WAIT;
          else if (left_dec == 3'd0)     phase_d = PH_IDLE;
          else                           phase_d = PH_ST0;
        end
        PH_WAIT: begin
          if (wait_dec != 8'd0)          phase_d = PH_WAIT;
          else if (left_q == 3'd0)       phase_d = PH_IDLE;
          else                           phase_d = PH_ST0;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Datapath and line levels
  always_comb begin
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    addr_d  = addr_q;
    wait_d  = wait_q;
    bl_d    = bl_q;
    pend_d  = pend_q;
    rs_d    = rs_q;
    nack_d  = nack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    light_d = light_q;
    done    = 1'b0;
    if (take) begin
      nack_d  = 1'b0;
      rs_d    = item_i.reg_select;
      light_d = (item_i.kind == KIND_LIGHT);
      case (item_i.kind)
        KIND_BYTE: begin
          pend_d = item_i.value;
          left_d = 3'd4;
        end
        KIND_NIBBLE: begin
          pend_d = item_i.value & NIB_LOW_MASK;
          left_d = 3'd2;
        end
        default: begin
          bl_d   = item_i.light_on;
          pend_d = item_i.light_on ? BIT_BL : 8'd0;
          left_d = 3'd1;
        end
      endcase
      addr_d  = 1'b1;
      shift_d = {cfg_i.slave_address, 1'b0};
      bit_d   = TOP_BIT;
    end else if (adv) begin
      unique case (phase_q)
        PH_ST0: sda_d = 1'b1;
        PH_ST1: scl_d = 1'b1;
        PH_ST2: sda_d = 1'b0;
        PH_ST3: scl_d = 1'b0;
        PH_B0:  sda_d = shift_q[bit_q];
        PH_B1:  scl_d = 1'b1;
        PH_B2: begin
          scl_d = 1'b0;
          if (bit_q != 3'd0) bit_d = bit_q - 3'd1;
        end
        PH_A0:  sda_d = 1'b1;
        PH_A1: begin
          scl_d = 1'b1;
          if (item_i.sda_in) nack_d = 1'b1;
        end
        PH_A2: begin
          scl_d = 1'b0;
          if (addr_q) begin
            addr_d  = 1'b0;
            shift_d = frame_data(light_q, pend_q, left_q, rs_q, bl_q);
            bit_d   = TOP_BIT;
          end
        end
        PH_P0:  sda_d = 1'b0;
        PH_P1:  scl_d = 1'b1;
        PH_P2: begin
          sda_d = 1'b1;
          if (last_frame) begin
            left_d = 3'd0;
            done   = 1'b1;
          end else begin
            wait_d = wait_sel;
            left_d = left_dec;
            if (wait_sel == 8'd0) begin
              if (left_dec == 3'd0) begin
                done = 1'b1;
              end else begin
                addr_d  = 1'b1;
                shift_d = {cfg_i.slave_address, 1'b0};
                bit_d   = TOP_BIT;
              end
            end
          end
        end
        PH_WAIT: begin
          wait_d = wait_dec;
          if (wait_dec == 8'd0) begin
            if (left_q == 3'd0) begin
              done = 1'b1;
            end else begin
              addr_d  = 1'b1;
              shift_d = {cfg_i.slave_address, 1'b0};
              bit_d   = TOP_BIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= TOP_BIT;
      shift_q <= 8'd0;
      left_q  <= 3'd0;
      addr_q  <= 1'b0;
      wait_q  <= 8'd0;
      bl_q    <= 1'b1;
      pend_q  <= 8'd0;
      rs_q    <= 1'b0;
      nack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      light_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      addr_q  <= addr_d;
      wait_q  <= wait_d;
      bl_q    <= bl_d;
      pend_q  <= pend_d;
      rs_q    <= rs_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      light_q <= light_d;
    end
  end

  // Result beat as it stands after this step
  always_comb begin
    res_o.scl_release = scl_d;
    res_o.sda_release = sda_d;
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.accepted    = take;
    res_o.nack_seen   = nack_d;
    res_o.done_res    = done;
  end

  // A taken command always opens a start condition
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (phase_q == PH_ST0))
    else $error("accepted command did not start a frame");

  // Finishing leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (phase_d == PH_IDLE))
    else $error("done raised while still busy");

  // The idle count is never empty while waiting
  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> (wait_q != 8'd0))
    else $error("wait phase with empty count");

endmodule
